/* rtl/tfbs_pkg.sv */
package tfbs_pkg;

    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int FRAME_W   = 11;
    localparam int SYM_CNT_W = 4;
    localparam int TICK_W    = 2;

    typedef logic [OP_W-1:0]      op_t;
    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [FRAME_W-1:0]   frame_t;
    typedef logic [SYM_CNT_W-1:0] sym_cnt_t;
    typedef logic [TICK_W-1:0]    tick_t;

    localparam op_t OP_DATA    = 2'd0;
    localparam op_t OP_SILENCE = 2'd1;
    localparam op_t OP_LEADER  = 2'd2;
    localparam op_t OP_NONE    = 2'd3;

    localparam sym_cnt_t SYMS_FRAMED = 4'd11;
    localparam sym_cnt_t SYMS_ALT    = 4'd8;

    localparam tick_t TICK_LAST_LONG  = 2'd3;
    localparam tick_t TICK_LAST_SHORT = 2'd1;

endpackage

/* rtl/tfbs_cmd_if.sv */
interface tfbs_cmd_if
    import tfbs_pkg::*;
;
    logic  valid;
    logic  ready;
    op_t   operation;
    byte_t data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

/* rtl/tfbs_tick_if.sv */
interface tfbs_tick_if;
    logic valid;
    logic ready;
    logic level;
    logic last;

    modport source (output valid, output level, output last, input ready);
    modport sink   (input valid, input level, input last, output ready);
endinterface

/* rtl/tape_fsk_byte_serializer.sv */
// channel | dir | words                | payload
// cmd     | in  | one group command    | operation[1:0], data_byte[7:0]
// ticks   | out | one level per tick   | level, last (set on final tick of a group)
// cfg     | in  | register write       | cfg_we, cfg_wdata (alt_mode)
//
// A group is loaded, then sent at one tick per cycle unless the output stalls:
// 44 ticks framed, 16 to 32 unframed. The symbol shift register and tick counter set those counts.
// A new command is taken once the final tick of the previous group is in the
// output register. Operation 3 is taken and dropped. Output stalls freeze the
// tick sequencer. rst_n clears control state and alt_mode asynchronously.
module tape_fsk_byte_serializer
    import tfbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tfbs_cmd_if.sink    cmd,
    tfbs_tick_if.source ticks,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic     state_reg, state_next;
    logic     alt_mode_reg;
    frame_t   sym_sr_reg, sym_sr_next;
    sym_cnt_t sym_cnt_reg, sym_cnt_next;
    tick_t    tick_reg, tick_next;
    logic     quiet_reg, quiet_next;
    logic     out_valid_reg, out_valid_next;
    logic     out_level_reg, out_level_next;
    logic     out_last_reg, out_last_next;

    logic cmd_fire;
    logic gen;
    logic short_sym;
    logic sym_end;
    logic grp_end;
    logic lvl;

    assign cmd.ready   = (state_reg == ST_IDLE);
    assign cmd_fire    = cmd.valid && cmd.ready && (cmd.operation != OP_NONE);
    assign gen         = (state_reg == ST_RUN) && (!out_valid_reg || ticks.ready);

    // unframed 1 symbol is only two ticks
    assign short_sym = alt_mode_reg && !quiet_reg && sym_sr_reg[0];
    assign sym_end   = short_sym ? (tick_reg == TICK_LAST_SHORT)
                                 : (tick_reg == TICK_LAST_LONG);
    assign grp_end   = sym_end && (sym_cnt_reg == sym_cnt_t'(1));

    always_comb
    begin
        if (quiet_reg)
            lvl = 1'b0;
        else if (sym_sr_reg[0])
            lvl = alt_mode_reg ^ tick_reg[0];
        else
            lvl = alt_mode_reg ^ tick_reg[1];
    end

    always_comb
    begin
        state_next     = state_reg;
        sym_sr_next    = sym_sr_reg;
        sym_cnt_next   = sym_cnt_reg;
        tick_next      = tick_reg;
        quiet_next     = quiet_reg;
        out_valid_next = out_valid_reg;
        out_level_next = out_level_reg;
        out_last_next  = out_last_reg;

        if (ticks.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next   = ST_RUN;
                    tick_next    = '0;
                    quiet_next   = (cmd.operation == OP_SILENCE);
                    sym_cnt_next = alt_mode_reg ? SYMS_ALT : SYMS_FRAMED;
                    case (cmd.operation)
                        OP_DATA:
                            sym_sr_next = alt_mode_reg
                                ? {3'b000, cmd.data_byte}
                                : {2'b11, cmd.data_byte, 1'b0};
                        OP_LEADER:
                            sym_sr_next = '1;
                        default:
                            sym_sr_next = '0;
                    endcase
                end
            end
            ST_RUN:
            begin
                if (gen)
                begin
                    out_valid_next = 1'b1;
                    out_level_next = lvl;
                    out_last_next  = grp_end;
                    if (sym_end)
                    begin
                        tick_next    = '0;
                        sym_sr_next  = sym_sr_reg >> 1;
                        sym_cnt_next = sym_cnt_reg - sym_cnt_t'(1);
                    end
                    else
                    begin
                        tick_next = tick_reg + tick_t'(1);
                    end
                    if (grp_end)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            alt_mode_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sym_cnt_reg   <= '0;
            tick_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sym_cnt_reg   <= sym_cnt_next;
            tick_reg      <= tick_next;
            if (cfg_we)
                alt_mode_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_sr_reg    <= sym_sr_next;
        quiet_reg     <= quiet_next;
        out_level_reg <= out_level_next;
        out_last_reg  <= out_last_next;
    end

    assign ticks.valid = out_valid_reg;
    assign ticks.level = out_level_reg;
    assign ticks.last  = out_last_reg;

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> (state_reg == ST_RUN) && (tick_reg == '0))
        else $error("command accepted but sequencer not started");

    a_run_has_syms: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (sym_cnt_reg != '0))
        else $error("running with no symbols left");

    a_short_sym_len: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && short_sym) |-> (tick_reg <= TICK_LAST_SHORT))
        else $error("short symbol overran two ticks");

    a_last_ends_group: assert property (@(posedge clk) disable iff (!rst_n)
        (gen && grp_end) |=> (state_reg == ST_IDLE) && ticks.valid && ticks.last)
        else $error("final tick did not close the group");

endmodule

/* tb/sv/tb_tape_fsk_byte_serializer.sv */
module tb_tape_fsk_byte_serializer
    import tfbs_pkg::*;
;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 64;
    localparam int RANDOM_PER_PHASE = 56;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        op_t   op;
        byte_t data;
    } group_cmd_t;

    typedef struct packed {
        logic level;
        logic last;
    } tick_word_t;

    typedef enum logic [1:0] {
        SYM_SPACE,
        SYM_MARK,
        SYM_QUIET
    } sym_kind_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;

    tfbs_cmd_if  cmd_if ();
    tfbs_tick_if tick_if ();

    tape_fsk_byte_serializer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if.sink),
        .ticks     (tick_if.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    // testbench copy of alt_mode
    logic unframed = 1'b0;

    group_cmd_t pending_cmds[$];
    tick_word_t expected_ticks[$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int mismatches = 0;
    int cycle_count = 0;
    group_cmd_t next_cmd;
    tick_word_t want;

    function automatic void push_tick(logic level);
        tick_word_t w;
        w.level = level;
        w.last  = 1'b0;
        expected_ticks.push_back(w);
    endfunction

    // Expands one group command into its tick levels at the current mode.
    function automatic void expand_group(op_t op, byte_t data);
        int nsym;
        logic base;
        sym_kind_t kind;
        if (op == OP_NONE)
            return;
        base = unframed;
        nsym = unframed ? int'(SYMS_ALT) : int'(SYMS_FRAMED);
        for (int s = 0; s < nsym; s++)
        begin
            if (op == OP_SILENCE)
                kind = SYM_QUIET;
            else if (op == OP_LEADER)
                kind = SYM_MARK;
            else if (unframed)
                kind = data[s] ? SYM_MARK : SYM_SPACE;
            else if (s == 0)
                kind = SYM_SPACE;
            else if (s <= 8)
                kind = data[s-1] ? SYM_MARK : SYM_SPACE;
            else
                kind = SYM_MARK;

            case (kind)
                SYM_QUIET:
                begin
                    repeat (4) push_tick(1'b0);
                end
                SYM_SPACE:
                begin
                    push_tick(base);
                    push_tick(base);
                    push_tick(~base);
                    push_tick(~base);
                end
                default:
                begin
                    push_tick(base);
                    push_tick(~base);
                    // framed mark repeats the pair
                    if (!unframed)
                    begin
                        push_tick(base);
                        push_tick(~base);
                    end
                end
            endcase
        end
        expected_ticks[expected_ticks.size()-1].last = 1'b1;
    endfunction

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_if.valid     <= 1'b0;
            cmd_if.operation <= OP_DATA;
            cmd_if.data_byte <= '0;
        end
        else
        begin
            if (cmd_if.valid && cmd_if.ready)
                expand_group(cmd_if.operation, cmd_if.data_byte);
            if (cmd_if.valid && !cmd_if.ready)
                cmd_if.valid <= 1'b1;
            else if (pending_cmds.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                next_cmd = pending_cmds.pop_front();
                cmd_if.valid     <= 1'b1;
                cmd_if.operation <= next_cmd.op;
                cmd_if.data_byte <= next_cmd.data;
            end
            else
                cmd_if.valid <= 1'b0;
        end
    end

    // tick sink: random backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_if.ready <= 1'b0;
        else
            tick_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // tick checker
    always @(posedge clk)
    begin
        if (rst_n && tick_if.valid && tick_if.ready)
        begin
            if (expected_ticks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected tick: level=%0b last=%0b",
                             tick_if.level, tick_if.last);
            end
            else
            begin
                want = expected_ticks.pop_front();
                if (tick_if.level !== want.level || tick_if.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"tick mismatch: expected level=%0b last=%0b,",
                                  " got level=%0b last=%0b"},
                                 want.level, want.last, tick_if.level, tick_if.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic queue_cmd(op_t op, byte_t data);
        group_cmd_t c;
        c.op   = op;
        c.data = data;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_directed();
        queue_cmd(OP_DATA, 8'h00);
        queue_cmd(OP_DATA, 8'hFF);
        queue_cmd(OP_DATA, 8'h01);
        queue_cmd(OP_DATA, 8'h80);
        queue_cmd(OP_DATA, 8'h55);
        queue_cmd(OP_DATA, 8'hAA);
        // byte field must not leak into silence or leader
        queue_cmd(OP_SILENCE, 8'hFF);
        queue_cmd(OP_SILENCE, 8'h00);
        queue_cmd(OP_LEADER, 8'hA5);
        queue_cmd(OP_NONE, 8'hFF);
        queue_cmd(OP_NONE, 8'h00);
        queue_cmd(OP_DATA, 8'h3C);
    endtask

    task automatic queue_random(int count);
        int pick;
        op_t op;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                op = OP_DATA;
            else if (pick < 75)
                op = OP_SILENCE;
            else if (pick < 90)
                op = OP_LEADER;
            else
                op = OP_NONE;
            queue_cmd(op, byte_t'($urandom_range(255)));
        end
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || cmd_if.valid || expected_ticks.size() > 0)
            @(posedge clk);
        // a dropped opcode leaves nothing to wait on; give the block time to settle
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(logic value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        unframed  = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(logic mode, int src_pct, int snk_pct, bit directed);
        wait_idle();
        write_mode(mode);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        if (directed)
            queue_directed();
        queue_random(RANDOM_PER_PHASE);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.operation = OP_DATA;
        cmd_if.data_byte = '0;
        tick_if.ready    = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        run_phase(1'b0, 0, 0, 1'b1);
        run_phase(1'b1, 0, 0, 1'b1);
        run_phase(1'b0, 64, 0, 1'b0);
        run_phase(1'b1, 64, 0, 1'b0);
        run_phase(1'b0, 0, 64, 1'b0);
        run_phase(1'b1, 0, 64, 1'b0);
        run_phase(1'b1, 33, 33, 1'b0);
        run_phase(1'b0, 33, 33, 1'b0);

        while (pending_cmds.size() > 0 || cmd_if.valid || expected_ticks.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/tfbs_pkg.sv
rtl/tfbs_cmd_if.sv
rtl/tfbs_tick_if.sv
rtl/tape_fsk_byte_serializer.sv
tb/sv/tb_tape_fsk_byte_serializer.sv
